// ===== rtl/core/i2c_register_access_sequencer_top_assert.svh =====
// ----------------------------------------------------------------------------
// I2C register sequencer assertion macros
// Shared assertion wrappers: clocked, reset-gated, report by $error.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_SEQUENCER_TOP_ASSERT_SVH
`define I2C_REGISTER_ACCESS_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication: when pre holds, post must hold.
`define I2CRAS_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("i2cras: same-cycle check failed");

// Next-cycle implication: when pre holds, post must hold in the next cycle.
`define I2CRAS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("i2cras: next-cycle check failed");

`endif

// ===== rtl/core/i2cras_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register sequencer package
// Command, status and step codes, state and result records, port widths.
// ----------------------------------------------------------------------------
package i2cras_pkg;

  localparam int unsigned InTdataW  = 32;
  localparam int unsigned InTuserW  = 2;
  localparam int unsigned OutTdataW = 24;
  localparam int unsigned OutTuserW = 5;

  localparam logic [7:0] ReadBit = 8'h01;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_EVENT = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_RXEN    = 3'd4,
    CMD_NACK    = 3'd5,
    CMD_STOP    = 3'd6,
    CMD_REINIT  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BUSY  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    STEP_NONE    = 4'd0,
    STEP_DEV     = 4'd1,
    STEP_REG     = 4'd2,
    STEP_BRANCH  = 4'd3,
    STEP_RD_DEV  = 4'd4,
    STEP_RX_EN   = 4'd5,
    STEP_CAPTURE = 4'd6,
    STEP_RD_STOP = 4'd7,
    STEP_WR_STOP = 4'd8,
    STEP_DONE    = 4'd9
  } step_e;

  typedef struct packed {
    step_e      step;
    status_e    status;
    logic [7:0] dev_sel;
    logic [7:0] reg_sel;
    logic       is_read;
    logic [7:0] tx_data;
    logic [7:0] rx_data;
  } seq_state_t;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] tx_byte;
    logic       accepted;
    logic       rx_valid;
    logic [7:0] rx_data;
    status_e    status;
  } seq_result_t;

endpackage

// ===== rtl/core/i2c_register_access_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// I2C register access sequencer
// Drives a byte-level I2C master engine through single-register reads and
// writes, one engine command per item.
// ----------------------------------------------------------------------------
//  channel  | dir | tuser                 | tdata
//  s_axis   | in  | action                | dev addr, reg addr, wr data, rx byte
//  m_axis   | out | command, acc, rx_vld  | tx byte, rx data, status
//
//  One item in, one item out. An item's result is ready in the cycle after it
//  is taken; sustained rate is one item per cycle while m_axis is not stalled,
//  set by the single output register behind the step logic.
//  Reset (rst_ni low, async) clears the sequencer state and empties the
//  output register.
//  While a result waits on m_axis, s_axis is held off only if m_axis_tready_i
//  is low; otherwise the next item is taken in the same cycle.
// ----------------------------------------------------------------------------
module i2c_register_access_sequencer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] device_address, [15:8] register_address, [23:16] write_data,
  // [31:24] engine_rx_byte
  input  logic [i2cras_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // [1:0] action
  input  logic [i2cras_pkg::InTuserW-1:0]  s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] tx_byte, [15:8] rx_data, [17:16] status, [23:18] zero
  output logic [i2cras_pkg::OutTdataW-1:0] m_axis_tdata_o,
  // [2:0] command, [3] accepted, [4] rx_valid
  output logic [i2cras_pkg::OutTuserW-1:0] m_axis_tuser_o
);
  import i2cras_pkg::*;

  seq_state_t  state_q, state_d;
  seq_result_t result;
  logic        out_valid_q, out_valid_d;
  logic [OutTdataW-1:0] out_tdata_q, out_tdata_d;
  logic [OutTuserW-1:0] out_tuser_q, out_tuser_d;
  logic        in_fire;

  // take a new item whenever the output slot is empty or draining now
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  i2cras_seq u_seq (
    .state_i    (state_q),
    .action_i   (action_e'(s_axis_tuser_i)),
    .dev_sel_i  (s_axis_tdata_i[7:0]),
    .reg_sel_i  (s_axis_tdata_i[15:8]),
    .wr_data_i  (s_axis_tdata_i[23:16]),
    .rx_byte_i  (s_axis_tdata_i[31:24]),
    .state_o    (state_d),
    .result_o   (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_tdata_d = out_tdata_q;
    out_tuser_d = out_tuser_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      out_tdata_d = {6'b0, result.status, result.rx_data, result.tx_byte};
      out_tuser_d = {result.rx_valid, result.accepted, result.command};
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // all-zero state is step none, status idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        state_q <= state_d;
      end
    end
  end

  // payload holds no reset
  always_ff @(posedge clk_i) begin
    out_tdata_q <= out_tdata_d;
    out_tuser_q <= out_tuser_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_tdata_q;
  assign m_axis_tuser_o  = out_tuser_q;

endmodule

// ===== rtl/core/i2cras_seq.sv =====
// ----------------------------------------------------------------------------
// I2C register sequencer step logic
// Combinational next state and result for one item.
// ----------------------------------------------------------------------------
module i2cras_seq (
  input  i2cras_pkg::seq_state_t  state_i,
  input  i2cras_pkg::action_e     action_i,
  input  logic [7:0]              dev_sel_i,
  input  logic [7:0]              reg_sel_i,
  input  logic [7:0]              wr_data_i,
  input  logic [7:0]              rx_byte_i,
  output i2cras_pkg::seq_state_t  state_o,
  output i2cras_pkg::seq_result_t result_o
);
  import i2cras_pkg::*;

  logic start_ok;
  assign start_ok = (state_i.status == ST_IDLE);

  // next state
  always_comb begin
    state_o = state_i;
    case (action_i)
      ACT_READ, ACT_WRITE: begin
        if (start_ok) begin
          state_o.status  = ST_BUSY;
          state_o.step    = STEP_DEV;
          state_o.dev_sel = dev_sel_i;
          state_o.reg_sel = reg_sel_i;
          state_o.is_read = (action_i == ACT_READ);
          if (action_i == ACT_WRITE) begin
            state_o.tx_data = wr_data_i;
          end
        end
      end
      ACT_EVENT: begin
        case (state_i.step)
          STEP_DEV:     state_o.step = STEP_REG;
          STEP_REG:     state_o.step = STEP_BRANCH;
          STEP_BRANCH:  state_o.step = state_i.is_read ? STEP_RD_DEV : STEP_WR_STOP;
          STEP_RD_DEV:  state_o.step = STEP_RX_EN;
          STEP_RX_EN:   state_o.step = STEP_CAPTURE;
          STEP_CAPTURE: begin
            state_o.rx_data = rx_byte_i;
            state_o.step    = STEP_RD_STOP;
          end
          STEP_RD_STOP, STEP_WR_STOP: state_o.step = STEP_DONE;
          STEP_DONE: begin
            state_o.status  = ST_IDLE;
            state_o.step    = STEP_NONE;
            state_o.is_read = 1'b0;
          end
          default: begin
            // event with nothing in flight
            state_o.status = ST_ERROR;
            state_o.step   = STEP_NONE;
          end
        endcase
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    result_o          = '0;
    result_o.command  = CMD_NONE;
    result_o.rx_data  = state_o.rx_data;
    result_o.status   = state_o.status;
    case (action_i)
      ACT_READ, ACT_WRITE: begin
        if (start_ok) begin
          result_o.command  = CMD_START;
          result_o.accepted = 1'b1;
        end
      end
      ACT_EVENT: begin
        case (state_i.step)
          STEP_DEV: begin
            result_o.command = CMD_SEND;
            result_o.tx_byte = state_i.dev_sel;
          end
          STEP_REG: begin
            result_o.command = CMD_SEND;
            result_o.tx_byte = state_i.reg_sel;
          end
          STEP_BRANCH: begin
            if (state_i.is_read) begin
              result_o.command = CMD_RESTART;
            end else begin
              result_o.command = CMD_SEND;
              result_o.tx_byte = state_i.tx_data;
            end
          end
          STEP_RD_DEV: begin
            result_o.command = CMD_SEND;
            result_o.tx_byte = state_i.dev_sel | ReadBit;
          end
          STEP_RX_EN:   result_o.command = CMD_RXEN;
          STEP_CAPTURE: begin
            result_o.command  = CMD_NACK;
            result_o.rx_valid = 1'b1;
          end
          STEP_RD_STOP, STEP_WR_STOP: result_o.command = CMD_STOP;
          STEP_DONE:    result_o.command = CMD_NONE;
          default:      result_o.command = CMD_REINIT;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/i2cras_checker.sv =====
// ----------------------------------------------------------------------------
// I2C register sequencer port checker
// Port-level checks, bound onto the top level.
// ----------------------------------------------------------------------------
`include "i2c_register_access_sequencer_top_assert.svh"

module i2cras_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [i2cras_pkg::InTdataW-1:0]  s_axis_tdata_i,
  input logic [i2cras_pkg::InTuserW-1:0]  s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [i2cras_pkg::OutTdataW-1:0] m_axis_tdata_o,
  input logic [i2cras_pkg::OutTuserW-1:0] m_axis_tuser_o
);
  import i2cras_pkg::*;

  logic in_fire;
  logic out_stall;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // a pending result is never overwritten
  `I2CRAS_ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, in_fire, !out_stall)
  // each taken item shows a result the next cycle
  `I2CRAS_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_fire, m_axis_tvalid_o)
  // stalled result holds
  `I2CRAS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  // a taken request issues START and reports busy
  `I2CRAS_ASSERT_IMPL(a_accept_start, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[3], (m_axis_tuser_o[2:0] == CMD_START) && (m_axis_tdata_o[17:16] == ST_BUSY))
  // captured read data goes with NACK
  `I2CRAS_ASSERT_IMPL(a_rx_nack, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[4], m_axis_tuser_o[2:0] == CMD_NACK)

endmodule

bind i2c_register_access_sequencer_top i2cras_checker u_i2cras_checker (.*);
